// ===== rtl/periodic_voxel_index_defines.svh =====
// Assertion macros for the periodic voxel index block.
// Included by RTL files that carry concurrent checks; needs nothing else.
`ifndef PERIODIC_VOXEL_INDEX_DEFINES_SVH
`define PERIODIC_VOXEL_INDEX_DEFINES_SVH

// Clocked check, disabled while reset is high
`define PVI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds through reset
`define PVI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/pvi_pkg.sv =====
// Shared constants, register indexes and arithmetic helpers for periodic_voxel_index.
// No dependencies.
`default_nettype none

package pvi_pkg;

   // Field widths
   localparam int COORD_W = 32;
   localparam int RECIP_W = 31;
   localparam int BIN_W   = 6;
   localparam int CSR_IDX_W = 3;
   localparam int SHIFT_W = 31;   // floor of a Q32.32 product of Q16.16 x Q16.16 (31-bit)
   localparam int PROD_W  = 63;   // signed product width of 32s x 31u or 32s x 31s

   // Default voxel counts
   localparam int NUM_BINS_Y_DEF = 64;
   localparam int NUM_BINS_Z_DEF = 64;

   // Reset value of the reciprocal voxel sizes (1.0 in Q16.16)
   localparam logic [RECIP_W-1:0] INV_CELL_RST = 31'd65536;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_USE_PERIODIC = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_Z       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_ZY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RECIP_EDGE_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RECIP_EDGE_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INV_CELL_Y   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INV_CELL_Z   = 3'd7;

   // Saturate a 64-bit signed difference to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // Floor a Q32.32 product to an integer and clamp to 0..n-1, keep BIN_W bits
   function automatic logic [BIN_W-1:0] bin_clamp(input logic signed [PROD_W-1:0] prod,
                                                  input int n);
      logic signed [SHIFT_W-1:0] b;
      logic signed [31:0]        b_ext;
      logic signed [31:0]        top;
      logic signed [31:0]        r;
      b     = prod[PROD_W-1:32];
      b_ext = 32'(b);
      top   = 32'(n - 1);
      if (b_ext < 0) begin
         r = 32'sd0;
      end else if (b_ext > top) begin
         r = top;
      end else begin
         r = b_ext;
      end
      return r[BIN_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/periodic_voxel_index.sv =====
// Top level of the periodic voxel index block: register file and binning pipeline.
// Depends on pvi_pkg and periodic_voxel_index_defines.svh.
//
// Usage:
//  - Input: drive req_pos_y / req_pos_z (signed Q16.16) with start high; the
//    transaction is taken at a rising edge where start is high and busy is low.
//    busy is always low, so a new position can be taken in every cycle.
//  - Output: rsp_valid strobes for one cycle with rsp_bin_y / rsp_bin_z. The
//    receiver cannot hold results off; it must take each one as it appears.
//  - Throughput: one transaction per cycle, sustained.
//  - The pipeline is the serial chain in periodic mode: z shift multiply,
//    shift times edge/shear multiply, subtract and saturate, y shift multiply,
//    y edge multiply, subtract and saturate, voxel multiply, floor and clamp,
//    each behind a register. Open mode runs through the same stages.
//  - Configuration: csr_valid/csr_ready write channel, csr_index selects the
//    register, csr_wdata carries the value. csr_ready is always high. Write only
//    while no transaction is in flight.
//  - Reset (synchronous, active high) clears the pipeline valid bits and
//    returns all registers to their defaults (inv_cell_y/z to 1.0, rest to 0).
`default_nettype none

`include "periodic_voxel_index_defines.svh"

module periodic_voxel_index #(
   parameter int NUM_BINS_Y = pvi_pkg::NUM_BINS_Y_DEF,
   parameter int NUM_BINS_Z = pvi_pkg::NUM_BINS_Z_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [pvi_pkg::COORD_W-1:0]  req_pos_y,
   input  wire logic signed [pvi_pkg::COORD_W-1:0]  req_pos_z,
   // Result channel
   output logic                                     rsp_valid,
   output logic [pvi_pkg::BIN_W-1:0]                rsp_bin_y,
   output logic [pvi_pkg::BIN_W-1:0]                rsp_bin_z,
   // Configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pvi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [31:0]                         csr_wdata
);

   localparam int CW = pvi_pkg::COORD_W;
   localparam int RW = pvi_pkg::RECIP_W;
   localparam int PW = pvi_pkg::PROD_W;
   localparam int SW = pvi_pkg::SHIFT_W;
   localparam int BW = pvi_pkg::BIN_W;
   localparam int LATENCY = 8;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic                 use_periodic_ff;
   logic signed [CW-1:0] edge_y_ff, edge_z_ff, shear_zy_ff;
   logic [RW-1:0]        recip_y_ff, recip_z_ff, inv_cell_y_ff, inv_cell_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_periodic_ff <= 1'b0;
         edge_y_ff       <= '0;
         edge_z_ff       <= '0;
         shear_zy_ff     <= '0;
         recip_y_ff      <= '0;
         recip_z_ff      <= '0;
         inv_cell_y_ff   <= pvi_pkg::INV_CELL_RST;
         inv_cell_z_ff   <= pvi_pkg::INV_CELL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pvi_pkg::REG_USE_PERIODIC: use_periodic_ff <= csr_wdata[0];
            pvi_pkg::REG_EDGE_Y:       edge_y_ff       <= csr_wdata;
            pvi_pkg::REG_EDGE_Z:       edge_z_ff       <= csr_wdata;
            pvi_pkg::REG_SHEAR_ZY:     shear_zy_ff     <= csr_wdata;
            pvi_pkg::REG_RECIP_EDGE_Y: recip_y_ff      <= csr_wdata[RW-1:0];
            pvi_pkg::REG_RECIP_EDGE_Z: recip_z_ff      <= csr_wdata[RW-1:0];
            pvi_pkg::REG_INV_CELL_Y:   inv_cell_y_ff   <= csr_wdata[RW-1:0];
            pvi_pkg::REG_INV_CELL_Z:   inv_cell_z_ff   <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Valid bits travel alongside the data
   // ---------------------------------------------------------------
   logic                 accept;
   logic [LATENCY-1:0]   valid_ff, valid_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      valid_in = {valid_ff[LATENCY-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: z shift product pos_z * recip_edge_z
   // ---------------------------------------------------------------
   logic signed [PW-1:0] s1_prod_ff, s1_prod_in;
   logic signed [CW-1:0] s1_py_ff, s1_pz_ff;

   assign s1_prod_in = req_pos_z * $signed({1'b0, recip_z_ff});

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_py_ff   <= req_pos_y;
      s1_pz_ff   <= req_pos_z;
   end

   // ---------------------------------------------------------------
   // Stage 2: shift times zz edge and shear; origin in open mode
   // ---------------------------------------------------------------
   logic signed [SW-1:0] s2_shift;
   logic signed [PW-1:0] s2_mz_ff, s2_mz_in, s2_my_ff, s2_my_in;
   logic signed [CW-1:0] s2_py_ff, s2_pz_ff;

   assign s2_shift = s1_prod_ff[PW-1:32];

   always_comb begin
      if (use_periodic_ff) begin
         s2_mz_in = edge_z_ff * s2_shift;
         s2_my_in = shear_zy_ff * s2_shift;
      end else begin
         s2_mz_in = {{(PW-CW){edge_z_ff[CW-1]}}, edge_z_ff};
         s2_my_in = {{(PW-CW){edge_y_ff[CW-1]}}, edge_y_ff};
      end
   end

   always_ff @(posedge clock) begin
      s2_mz_ff <= s2_mz_in;
      s2_my_ff <= s2_my_in;
      s2_py_ff <= s1_py_ff;
      s2_pz_ff <= s1_pz_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: subtract and saturate both coordinates
   // ---------------------------------------------------------------
   logic signed [63:0]   s3_dz, s3_dy;
   logic signed [CW-1:0] s3_cz_ff, s3_cy_ff;

   assign s3_dz = {{(64-CW){s2_pz_ff[CW-1]}}, s2_pz_ff} - {s2_mz_ff[PW-1], s2_mz_ff};
   assign s3_dy = {{(64-CW){s2_py_ff[CW-1]}}, s2_py_ff} - {s2_my_ff[PW-1], s2_my_ff};

   always_ff @(posedge clock) begin
      s3_cz_ff <= pvi_pkg::sat32(s3_dz);
      s3_cy_ff <= pvi_pkg::sat32(s3_dy);
   end

   // ---------------------------------------------------------------
   // Stage 4: y shift product and z voxel product
   // ---------------------------------------------------------------
   logic signed [PW-1:0] s4_yprod_ff, s4_bz_ff;
   logic signed [CW-1:0] s4_cy_ff;

   always_ff @(posedge clock) begin
      s4_yprod_ff <= s3_cy_ff * $signed({1'b0, recip_y_ff});
      s4_bz_ff    <= s3_cz_ff * $signed({1'b0, inv_cell_z_ff});
      s4_cy_ff    <= s3_cy_ff;
   end

   // ---------------------------------------------------------------
   // Stage 5: y shift times yy edge; nothing more to remove in open mode
   // ---------------------------------------------------------------
   logic signed [SW-1:0] s5_shift;
   logic signed [PW-1:0] s5_my_ff, s5_my_in, s5_bz_ff;
   logic signed [CW-1:0] s5_cy_ff;

   assign s5_shift = s4_yprod_ff[PW-1:32];

   always_comb begin
      if (use_periodic_ff) begin
         s5_my_in = edge_y_ff * s5_shift;
      end else begin
         s5_my_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      s5_my_ff <= s5_my_in;
      s5_bz_ff <= s4_bz_ff;
      s5_cy_ff <= s4_cy_ff;
   end

   // ---------------------------------------------------------------
   // Stage 6: wrap y and saturate
   // ---------------------------------------------------------------
   logic signed [63:0]   s6_dy;
   logic signed [CW-1:0] s6_cy_ff;
   logic signed [PW-1:0] s6_bz_ff;

   assign s6_dy = {{(64-CW){s5_cy_ff[CW-1]}}, s5_cy_ff} - {s5_my_ff[PW-1], s5_my_ff};

   always_ff @(posedge clock) begin
      s6_cy_ff <= pvi_pkg::sat32(s6_dy);
      s6_bz_ff <= s5_bz_ff;
   end

   // ---------------------------------------------------------------
   // Stage 7: y voxel product
   // ---------------------------------------------------------------
   logic signed [PW-1:0] s7_by_ff, s7_bz_ff;

   always_ff @(posedge clock) begin
      s7_by_ff <= s6_cy_ff * $signed({1'b0, inv_cell_y_ff});
      s7_bz_ff <= s6_bz_ff;
   end

   // ---------------------------------------------------------------
   // Stage 8: floor, clamp to the grid, output register
   // ---------------------------------------------------------------
   logic [BW-1:0] bin_y_ff, bin_z_ff;

   always_ff @(posedge clock) begin
      bin_y_ff <= pvi_pkg::bin_clamp(s7_by_ff, NUM_BINS_Y);
      bin_z_ff <= pvi_pkg::bin_clamp(s7_bz_ff, NUM_BINS_Z);
   end

   assign rsp_valid = valid_ff[LATENCY-1];
   assign rsp_bin_y = bin_y_ff;
   assign rsp_bin_z = bin_z_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `PVI_ASSERT(a_latency, clock, reset, accept |-> ##8 rsp_valid, "result strobe missing after accept")
   `PVI_ASSERT(a_bin_y_range, clock, reset, rsp_valid |-> (int'(rsp_bin_y) <= NUM_BINS_Y - 1), "bin_y beyond grid")
   `PVI_ASSERT(a_bin_z_range, clock, reset, rsp_valid |-> (int'(rsp_bin_z) <= NUM_BINS_Z - 1), "bin_z beyond grid")
   `PVI_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> (valid_ff == '0), "pipeline not flushed by reset")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for periodic_voxel_index: directed table, then random grid phases.
// Depends on pvi_pkg and the periodic_voxel_index RTL; carries its own bin predictor.
module tb;

   localparam int        N_DIRECTED    = 41;
   localparam int        N_PHASES      = 12;
   localparam int        ITEMS_PER_PHASE = 155;
   localparam int        STALL_LIMIT   = 1000;
   localparam int        DRAIN_CYCLES  = 16;
   localparam longint    COORD_MAX     = 64'sd2147483647;
   localparam longint    COORD_MIN     = -64'sd2147483648;

   typedef enum logic { ROW_POS, ROW_CSR } row_kind_type;
   typedef enum int { GRID_BOX, GRID_OPEN, GRID_RAW, GRID_EXTREME } grid_style_type;

   typedef struct packed {
      logic [pvi_pkg::BIN_W-1:0] y;
      logic [pvi_pkg::BIN_W-1:0] z;
   } voxel_pair_type;

   // a: position y or register data, b: position z; known rows carry typed bins
   typedef struct packed {
      row_kind_type                  kind;
      logic [pvi_pkg::CSR_IDX_W-1:0] idx;
      logic [31:0]                   a;
      logic [31:0]                   b;
      logic                          known;
      logic [pvi_pkg::BIN_W-1:0]     by;
      logic [pvi_pkg::BIN_W-1:0]     bz;
   } stim_row_type;

   typedef struct {
      logic   periodic;
      longint edge_y;
      longint edge_z;
      longint shear;
      longint rcp_y;
      longint rcp_z;
      longint inv_y;
      longint inv_z;
   } grid_cfg_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [pvi_pkg::COORD_W-1:0]   req_pos_y = '0;
   logic [pvi_pkg::COORD_W-1:0]   req_pos_z = '0;
   logic                          rsp_valid;
   logic [pvi_pkg::BIN_W-1:0]     rsp_bin_y;
   logic [pvi_pkg::BIN_W-1:0]     rsp_bin_z;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pvi_pkg::CSR_IDX_W-1:0] csr_index = pvi_pkg::REG_USE_PERIODIC;
   logic [31:0]                   csr_wdata = '0;

   // typed expectation travels with the driven transaction
   logic                 req_typed = 1'b0;
   voxel_pair_type       req_typed_bins = '0;

   grid_cfg_type   cfg = '{1'b0, 0, 0, 0, 0, 0, 65536, 65536};
   voxel_pair_type pending_bins[$];
   int             error_count = 0;
   int             stall_cycles = 0;
   logic           sender_idles = 1'b1;
   logic           grid_sane = 1'b0;
   logic [31:0]    pos_span = '0;

   grid_style_type phase_style [N_PHASES] = '{GRID_BOX, GRID_OPEN, GRID_RAW, GRID_BOX,
      GRID_EXTREME, GRID_BOX, GRID_OPEN, GRID_RAW, GRID_BOX, GRID_EXTREME, GRID_BOX,
      GRID_OPEN};

   stim_row_type directed_rows [N_DIRECTED] = '{
      // reset grid: open mode, zero origin, unit voxels
      '{ROW_POS, '0, 32'h0000_0000, 32'h0000_0000, 1'b1, 6'd0,  6'd0},
      '{ROW_POS, '0, 32'h0005_0000, 32'h003F_8000, 1'b1, 6'd5,  6'd63},
      '{ROW_POS, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 6'd63, 6'd63},
      '{ROW_POS, '0, 32'h8000_0000, 32'h8000_0000, 1'b1, 6'd0,  6'd0},
      '{ROW_POS, '0, 32'hFFFF_FFFF, 32'h0040_0000, 1'b1, 6'd0,  6'd63},
      // origins at both extremes, differences saturate
      '{ROW_CSR, pvi_pkg::REG_EDGE_Y, 32'h8000_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_EDGE_Z, 32'h7FFF_FFFF, '0, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 6'd63, 6'd0},
      '{ROW_POS, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 6'd0,  6'd0},
      // largest and zero voxel reciprocals
      '{ROW_CSR, pvi_pkg::REG_INV_CELL_Y, 32'h7FFF_FFFF, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_INV_CELL_Z, 32'h0000_0000, '0, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h8001_0000, 32'h1234_5678, 1'b1, 6'd63, 6'd0},
      '{ROW_POS, '0, 32'h8000_0001, 32'h7FFF_FFFF, 1'b0, '0, '0},
      // periodic box 8 x 10 with a shear of 2
      '{ROW_CSR, pvi_pkg::REG_USE_PERIODIC, 32'h0000_0001, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_EDGE_Y,       32'h0008_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_EDGE_Z,       32'h000A_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_SHEAR_ZY,     32'h0002_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_RECIP_EDGE_Y, 32'h0000_2000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_RECIP_EDGE_Z, 32'h0000_199A, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_INV_CELL_Y,   32'h0008_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_INV_CELL_Z,   32'h0006_6666, '0, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h0001_0000, 32'h0001_0000, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h0007_E666, 32'h000C_8000, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'hFFFD_0000, 32'hFFFC_0000, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h0008_0000, 32'h000A_0000, 1'b0, '0, '0},
      // zero reciprocal edges: coordinates pass unwrapped
      '{ROW_CSR, pvi_pkg::REG_RECIP_EDGE_Y, 32'h0000_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_RECIP_EDGE_Z, 32'h0000_0000, '0, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h0014_0000, 32'h0019_0000, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'hFFFB_0000, 32'h0003_0000, 1'b0, '0, '0},
      // box registers at their extremes
      '{ROW_CSR, pvi_pkg::REG_RECIP_EDGE_Y, 32'h7FFF_FFFF, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_RECIP_EDGE_Z, 32'h7FFF_FFFF, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_SHEAR_ZY,     32'h8000_0000, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_EDGE_Y,       32'h7FFF_FFFF, '0, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_EDGE_Z,       32'h8000_0000, '0, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h1234_5678, 32'hEDCB_A987, 1'b0, '0, '0},
      '{ROW_CSR, pvi_pkg::REG_SHEAR_ZY,     32'h7FFF_FFFF, '0, 1'b0, '0, '0},
      '{ROW_POS, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, '0}
   };

   periodic_voxel_index u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .rsp_valid (rsp_valid),
      .rsp_bin_y (rsp_bin_y),
      .rsp_bin_z (rsp_bin_z),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---- bin predictor ----

   function automatic longint clip_coord(input longint v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   // floor(coord * inv / 2^32), clamped to the grid and cut to the port width
   function automatic logic [pvi_pkg::BIN_W-1:0] voxel_bin(input longint coord,
                                                          input longint inv,
                                                          input int n);
      longint b;
      b = (coord * inv) >>> 32;
      if (b < 0) begin
         b = 0;
      end
      if (b > n - 1) begin
         b = n - 1;
      end
      return b[pvi_pkg::BIN_W-1:0];
   endfunction

   function automatic voxel_pair_type bin_position(input logic [31:0] y_raw,
                                                  input logic [31:0] z_raw);
      longint         py, pz, cy, cz, sy, sz;
      voxel_pair_type r;
      py = $signed(y_raw);
      pz = $signed(z_raw);
      if (cfg.periodic) begin
         // z shift also drags y along the shear vector
         sz = (pz * cfg.rcp_z) >>> 32;
         cz = clip_coord(pz - cfg.edge_z * sz);
         cy = clip_coord(py - cfg.shear * sz);
         sy = (cy * cfg.rcp_y) >>> 32;
         cy = clip_coord(cy - cfg.edge_y * sy);
      end else begin
         cy = clip_coord(py - cfg.edge_y);
         cz = clip_coord(pz - cfg.edge_z);
      end
      r.y = voxel_bin(cy, cfg.inv_y, pvi_pkg::NUM_BINS_Y_DEF);
      r.z = voxel_bin(cz, cfg.inv_z, pvi_pkg::NUM_BINS_Z_DEF);
      return r;
   endfunction

   // ---- monitor: register writes, accepted positions, result check, watchdog ----
   always @(posedge clock) begin
      voxel_pair_type exp_bins;
      voxel_pair_type acc_bins;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pvi_pkg::REG_USE_PERIODIC: cfg.periodic = csr_wdata[0];
               pvi_pkg::REG_EDGE_Y:       cfg.edge_y   = $signed(csr_wdata);
               pvi_pkg::REG_EDGE_Z:       cfg.edge_z   = $signed(csr_wdata);
               pvi_pkg::REG_SHEAR_ZY:     cfg.shear    = $signed(csr_wdata);
               pvi_pkg::REG_RECIP_EDGE_Y: cfg.rcp_y    = csr_wdata[pvi_pkg::RECIP_W-1:0];
               pvi_pkg::REG_RECIP_EDGE_Z: cfg.rcp_z    = csr_wdata[pvi_pkg::RECIP_W-1:0];
               pvi_pkg::REG_INV_CELL_Y:   cfg.inv_y    = csr_wdata[pvi_pkg::RECIP_W-1:0];
               pvi_pkg::REG_INV_CELL_Z:   cfg.inv_z    = csr_wdata[pvi_pkg::RECIP_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            acc_bins = req_typed ? req_typed_bins : bin_position(req_pos_y, req_pos_z);
            pending_bins = {pending_bins, acc_bins};
         end
         if (rsp_valid) begin
            if (pending_bins.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected result: bin_y %0d bin_z %0d", rsp_bin_y, rsp_bin_z);
               end
            end else begin
               exp_bins = pending_bins.pop_front();
               if (rsp_bin_y !== exp_bins.y || rsp_bin_z !== exp_bins.z) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("mismatch: bin_y exp %0d got %0d, bin_z exp %0d got %0d",
                              exp_bins.y, rsp_bin_y, exp_bins.z, rsp_bin_z);
                  end
               end
            end
         end
         if ((start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   // ---- drivers ----

   task automatic send_position(input logic [31:0] y, input logic [31:0] z,
                                input logic known, input voxel_pair_type typed);
      while (sender_idles && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_pos_y      <= y;
      req_pos_z      <= z;
      req_typed      <= known;
      req_typed_bins <= typed;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pvi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      while (sender_idles && $urandom_range(0, 99) < 8) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop sending and wait until every result has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending_bins.size() != 0);
   endtask

   function automatic logic [31:0] extreme_word();
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // pick a grid setting of the given style and write all registers
   task automatic load_grid(input grid_style_type style);
      logic [31:0] per, ey, ez, sh, ry, rz, iy, iz;
      int          nby, nbz;
      nby = $urandom_range(1, 80);
      nbz = $urandom_range(1, 80);
      case (style)
         GRID_BOX: begin
            per = 32'd1;
            ey  = $urandom_range(32'h0001_0000, 32'h00C8_0000);
            ez  = $urandom_range(32'h0001_0000, 32'h00C8_0000);
            sh  = $urandom_range(0, 2 * ey) - ey;
            ry  = 32'((64'd1 << 32) / 64'(ey));
            rz  = 32'((64'd1 << 32) / 64'(ez));
            iy  = 32'((64'(nby) << 32) / 64'(ey));
            iz  = 32'((64'(nbz) << 32) / 64'(ez));
            grid_sane = 1'b1;
            pos_span  = (ey > ez) ? ey : ez;
         end
         GRID_OPEN: begin
            per = 32'd0;
            ey  = $urandom_range(0, 32'h0190_0000) - 32'h00C8_0000;
            ez  = $urandom_range(0, 32'h0190_0000) - 32'h00C8_0000;
            sh  = $urandom;
            ry  = $urandom;
            rz  = $urandom;
            iy  = $urandom_range(0, 32'h0010_0000);
            iz  = $urandom_range(0, 32'h0010_0000);
            grid_sane = 1'b1;
            pos_span  = 32'h00C8_0000;
         end
         GRID_RAW: begin
            per = $urandom_range(0, 1);
            ey  = $urandom;
            ez  = $urandom;
            sh  = $urandom;
            ry  = $urandom;
            rz  = $urandom;
            iy  = $urandom;
            iz  = $urandom;
            grid_sane = 1'b0;
         end
         default: begin
            per = $urandom_range(0, 1);
            ey  = extreme_word();
            ez  = extreme_word();
            sh  = extreme_word();
            ry  = extreme_word();
            rz  = extreme_word();
            iy  = extreme_word();
            iz  = extreme_word();
            grid_sane = 1'b0;
         end
      endcase
      write_csr(pvi_pkg::REG_USE_PERIODIC, per);
      write_csr(pvi_pkg::REG_EDGE_Y, ey);
      write_csr(pvi_pkg::REG_EDGE_Z, ez);
      write_csr(pvi_pkg::REG_SHEAR_ZY, sh);
      write_csr(pvi_pkg::REG_RECIP_EDGE_Y, ry & 32'h7FFF_FFFF);
      write_csr(pvi_pkg::REG_RECIP_EDGE_Z, rz & 32'h7FFF_FFFF);
      write_csr(pvi_pkg::REG_INV_CELL_Y, iy & 32'h7FFF_FFFF);
      write_csr(pvi_pkg::REG_INV_CELL_Z, iz & 32'h7FFF_FFFF);
      csr_valid <= 1'b0;
   endtask

   // ---- stimulus ----
   initial begin
      stim_row_type row;
      logic         prev_csr;
      logic [31:0]  y, z;
      prev_csr = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (!prev_csr) begin
               settle();
            end
            write_csr(row.idx, row.a);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr) begin
               csr_valid <= 1'b0;
            end
            send_position(row.a, row.b, row.known, {row.by, row.bz});
            prev_csr = 1'b0;
         end
      end

      // random phases, one grid setting each; one phase runs without gaps
      for (int phase = 0; phase < N_PHASES; phase++) begin
         settle();
         sender_idles = (phase != 4);
         load_grid(phase_style[phase]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (grid_sane && $urandom_range(0, 99) < 75) begin
               y = $urandom_range(0, 5 * pos_span) - 2 * pos_span;
               z = $urandom_range(0, 5 * pos_span) - 2 * pos_span;
            end else begin
               y = $urandom;
               z = $urandom;
            end
            send_position(y, z, 1'b0, '0);
         end
      end

      // drain, then give stray results time to show up
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += pending_bins.size();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== periodic_voxel_index.f =====
+incdir+rtl
rtl/pvi_pkg.sv
rtl/periodic_voxel_index.sv
tb/tb.sv
